// ===== hdl/csalu_pkg.sv =====
// Shared types and constants for the checked signed ALU with power.
// Used by csalu_core and by the top level; depends on nothing.
package csalu_pkg;

	// Datapath widths.
	localparam int DATA_W = 64;
	localparam int HALF_W = 32;
	localparam int ACC_W  = 97;
	localparam int EXT_W  = ACC_W - DATA_W;
	localparam int EXP_W  = 6;

	// Operation codes.
	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_POW = 3'd4;

	// Value constants.
	localparam logic [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic [DATA_W-1:0] VAL_ZERO = '0;
	localparam logic [DATA_W-1:0] VAL_ONE  = {{(DATA_W-1){1'b0}}, 1'b1};
	localparam logic [DATA_W-1:0] VAL_MONE = '1;
	localparam logic [DATA_W-1:0] MAX_EXP  = 64'd62;
	localparam logic [2:0]        EXP_TOP  = 3'd5;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAGA,
		ST_MAGB,
		ST_ADD,
		ST_MUL,
		ST_DIV,
		ST_POW,
		ST_SIGN,
		ST_DONE
	} state_t;

	// Requests from the top level to the core.
	typedef struct packed {
		logic start;
		logic take;
	} core_req_t;

	// Status from the core to the top level.
	typedef struct packed {
		logic idle;
		logic done;
	} core_sts_t;

endpackage

// ===== hdl/checked_signed_alu_with_power_unit.sv =====
// Top level of the checked signed ALU with power: handshakes and result register.
// Depends on csalu_pkg and csalu_core.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+-----------------------------------
//   input   | in_valid  | in_stall  | opcode, operand_a, operand_b
//   output  | out_valid | out_stall | value, fault
//
// Each operation is stepped by the sequencer through the shared adder and the 32x32
// multiplier; divide runs one quotient bit per cycle. The input stalls while the core
// holds a word; a finished word waits in the core until the output register is free,
// and the next input is taken once it has moved there.
// Reset is asynchronous and clears the sequencer and the output valid flag.
module checked_signed_alu_with_power_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [2:0]                          opcode,
	input  logic signed [csalu_pkg::DATA_W-1:0] operand_a,
	input  logic signed [csalu_pkg::DATA_W-1:0] operand_b,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [csalu_pkg::DATA_W-1:0] value,
	output logic                                fault
);

	csalu_pkg::core_req_t         req;
	csalu_pkg::core_sts_t         sts;
	logic [csalu_pkg::DATA_W-1:0] core_value;
	logic                         core_fault;
	logic                         out_valid_q;
	logic [csalu_pkg::DATA_W-1:0] value_q;
	logic                         fault_q;

	// A new word starts only when the core is idle; a result moves out when the register frees.
	assign in_stall  = !sts.idle;
	assign req.start = in_valid && !in_stall;
	assign req.take  = sts.done && (!out_valid_q || !out_stall);

	csalu_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.opcode    (opcode),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.sts       (sts),
		.value     (core_value),
		.fault     (core_fault)
	);

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (req.take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (req.take) begin
			value_q <= core_value;
			fault_q <= core_fault;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign fault     = fault_q;

endmodule

// ===== hdl/csalu_core.sv =====
// Sequencer and shared datapath: one 97-bit adder and one 32x32 multiplier.
// Computes one result word at a time; depends on csalu_pkg.
module csalu_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  csalu_pkg::core_req_t         req,
	input  logic [2:0]                   opcode,
	input  logic [csalu_pkg::DATA_W-1:0] operand_a,
	input  logic [csalu_pkg::DATA_W-1:0] operand_b,
	output csalu_pkg::core_sts_t         sts,
	output logic [csalu_pkg::DATA_W-1:0] value,
	output logic                         fault
);

	csalu_pkg::state_t state_q, state_d;

	logic [2:0]                   op_q;
	logic [csalu_pkg::DATA_W-1:0] a_q, b_q, res_q;
	logic                         neg_q, fault_q;
	logic [csalu_pkg::DATA_W-1:0] mx_q, my_q, pp_q;
	logic [csalu_pkg::ACC_W-1:0]  acc_q;
	logic [2:0]                   mstep_q;
	logic [csalu_pkg::DATA_W-1:0] rem_q, quo_q;
	logic [5:0]                   cnt_q;
	logic [2:0]                   ebit_q;
	logic                         half_q, last_q;

	logic [csalu_pkg::ACC_W-1:0]  add_x, add_y, add_sum;
	logic                         add_cin;
	logic [csalu_pkg::HALF_W-1:0] mul_x, mul_y;
	logic [csalu_pkg::DATA_W-1:0] mul_p;
	logic                         mul_ovf;
	logic [csalu_pkg::DATA_W-1:0] div_shift;
	logic                         div_ge;
	logic                         add_ok;
	logic [csalu_pkg::DATA_W-1:0] abs_b;
	logic [csalu_pkg::EXP_W-1:0]  exp_bits;
	logic [csalu_pkg::ACC_W-1:0]  sext_a, sext_b;

	logic                         in_min;
	logic                         pre_fault, pre_neg;
	logic [csalu_pkg::DATA_W-1:0] pre_res;
	csalu_pkg::state_t            pre_next;

	// The shared adder serves negation, add and subtract, accumulation and trial subtraction.
	assign add_sum = add_x + add_y + {{(csalu_pkg::ACC_W-1){1'b0}}, add_cin};

	// One quarter of the 63 by 63 bit product per cycle.
	always_comb begin
		case (mstep_q)
			3'd0: begin
				mul_x = mx_q[csalu_pkg::HALF_W-1:0];
				mul_y = my_q[csalu_pkg::HALF_W-1:0];
			end
			3'd1: begin
				mul_x = mx_q[csalu_pkg::HALF_W-1:0];
				mul_y = my_q[csalu_pkg::DATA_W-1:csalu_pkg::HALF_W];
			end
			3'd2: begin
				mul_x = mx_q[csalu_pkg::DATA_W-1:csalu_pkg::HALF_W];
				mul_y = my_q[csalu_pkg::HALF_W-1:0];
			end
			default: begin
				mul_x = mx_q[csalu_pkg::DATA_W-1:csalu_pkg::HALF_W];
				mul_y = my_q[csalu_pkg::DATA_W-1:csalu_pkg::HALF_W];
			end
		endcase
	end
	assign mul_p = mul_x * mul_y;

	// The product overflows when the high partial product or any bit above the range is set.
	assign mul_ovf = (pp_q != '0) || (acc_q[csalu_pkg::ACC_W-1:csalu_pkg::DATA_W-1] != '0);

	// Restoring division: shift in the next dividend bit and try to subtract.
	assign div_shift = {rem_q[csalu_pkg::DATA_W-2:0], quo_q[csalu_pkg::DATA_W-1]};
	assign div_ge    = !add_sum[csalu_pkg::ACC_W-1];

	// Signed add result must stay within the symmetric range.
	assign add_ok = ((add_sum[csalu_pkg::ACC_W-1:csalu_pkg::DATA_W-1] == '0) ||
		(&add_sum[csalu_pkg::ACC_W-1:csalu_pkg::DATA_W-1])) &&
		(add_sum[csalu_pkg::DATA_W-1:0] != csalu_pkg::MOST_NEG);

	assign sext_a   = {{csalu_pkg::EXT_W{a_q[csalu_pkg::DATA_W-1]}}, a_q};
	assign sext_b   = {{csalu_pkg::EXT_W{b_q[csalu_pkg::DATA_W-1]}}, b_q};
	assign abs_b    = b_q[csalu_pkg::DATA_W-1] ? add_sum[csalu_pkg::DATA_W-1:0] : b_q;
	assign exp_bits = b_q[csalu_pkg::EXP_W-1:0];

	// Decode of a new word: out-of-range operands, divide by zero, bad codes and the power special cases.
	assign in_min = (operand_a == csalu_pkg::MOST_NEG) || (operand_b == csalu_pkg::MOST_NEG);

	always_comb begin
		pre_fault = 1'b0;
		pre_neg   = 1'b0;
		pre_res   = csalu_pkg::VAL_ZERO;
		pre_next  = csalu_pkg::ST_DONE;
		if (in_min) begin
			pre_fault = 1'b1;
		end else begin
			case (opcode)
				csalu_pkg::OP_ADD, csalu_pkg::OP_SUB: begin
					pre_next = csalu_pkg::ST_ADD;
				end
				csalu_pkg::OP_MUL: begin
					pre_neg  = operand_a[csalu_pkg::DATA_W-1] ^ operand_b[csalu_pkg::DATA_W-1];
					pre_next = csalu_pkg::ST_MAGA;
				end
				csalu_pkg::OP_DIV: begin
					if (operand_b == csalu_pkg::VAL_ZERO) begin
						pre_fault = 1'b1;
					end else begin
						pre_neg  = operand_a[csalu_pkg::DATA_W-1] ^ operand_b[csalu_pkg::DATA_W-1];
						pre_next = csalu_pkg::ST_MAGA;
					end
				end
				csalu_pkg::OP_POW: begin
					if (operand_a == csalu_pkg::VAL_ZERO && operand_b == csalu_pkg::VAL_ZERO) begin
						pre_fault = 1'b1;
					end else if (operand_b[csalu_pkg::DATA_W-1]) begin
						pre_res = csalu_pkg::VAL_ZERO;
					end else if (operand_b == csalu_pkg::VAL_ZERO) begin
						pre_res = csalu_pkg::VAL_ONE;
					end else if (operand_a == csalu_pkg::VAL_ZERO) begin
						pre_res = csalu_pkg::VAL_ZERO;
					end else if (operand_a == csalu_pkg::VAL_ONE) begin
						pre_res = csalu_pkg::VAL_ONE;
					end else if (operand_a == csalu_pkg::VAL_MONE) begin
						pre_res = operand_b[0] ? csalu_pkg::VAL_MONE : csalu_pkg::VAL_ONE;
					end else if (operand_b > csalu_pkg::MAX_EXP) begin
						pre_fault = 1'b1;
					end else begin
						pre_neg  = operand_a[csalu_pkg::DATA_W-1] & operand_b[0];
						pre_res  = csalu_pkg::VAL_ONE;
						pre_next = csalu_pkg::ST_MAGA;
					end
				end
				default: begin
					pre_fault = 1'b1;
				end
			endcase
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= csalu_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and adder operand selection.
	always_comb begin
		state_d = state_q;
		add_x   = '0;
		add_y   = '0;
		add_cin = 1'b0;
		case (state_q)
			csalu_pkg::ST_IDLE: begin
				if (req.start) begin
					state_d = pre_next;
				end
			end
			csalu_pkg::ST_MAGA: begin
				add_y   = ~{{csalu_pkg::EXT_W{1'b0}}, a_q};
				add_cin = 1'b1;
				state_d = (op_q == csalu_pkg::OP_POW) ? csalu_pkg::ST_POW : csalu_pkg::ST_MAGB;
			end
			csalu_pkg::ST_MAGB: begin
				add_y   = ~{{csalu_pkg::EXT_W{1'b0}}, b_q};
				add_cin = 1'b1;
				state_d = (op_q == csalu_pkg::OP_MUL) ? csalu_pkg::ST_MUL : csalu_pkg::ST_DIV;
			end
			csalu_pkg::ST_ADD: begin
				add_x   = sext_a;
				add_y   = (op_q == csalu_pkg::OP_SUB) ? ~sext_b : sext_b;
				add_cin = (op_q == csalu_pkg::OP_SUB);
				state_d = csalu_pkg::ST_DONE;
			end
			csalu_pkg::ST_MUL: begin
				add_x = acc_q;
				if (mstep_q == 3'd1) begin
					add_y = {{csalu_pkg::EXT_W{1'b0}}, pp_q};
				end else if (mstep_q == 3'd2 || mstep_q == 3'd3) begin
					add_y = {{csalu_pkg::EXT_W{1'b0}}, pp_q} << csalu_pkg::HALF_W;
				end
				if (mstep_q == 3'd4) begin
					if (mul_ovf) begin
						state_d = csalu_pkg::ST_DONE;
					end else if (op_q == csalu_pkg::OP_POW) begin
						state_d = csalu_pkg::ST_POW;
					end else begin
						state_d = csalu_pkg::ST_SIGN;
					end
				end
			end
			csalu_pkg::ST_DIV: begin
				add_x   = {{csalu_pkg::EXT_W{1'b0}}, div_shift};
				add_y   = ~{{csalu_pkg::EXT_W{1'b0}}, b_q};
				add_cin = 1'b1;
				if (cnt_q == 6'd63) begin
					state_d = csalu_pkg::ST_SIGN;
				end
			end
			csalu_pkg::ST_POW: begin
				if (!half_q) begin
					state_d = last_q ? csalu_pkg::ST_SIGN : csalu_pkg::ST_MUL;
				end else if (exp_bits[ebit_q]) begin
					state_d = csalu_pkg::ST_MUL;
				end
			end
			csalu_pkg::ST_SIGN: begin
				add_y   = ~{{csalu_pkg::EXT_W{1'b0}}, res_q};
				add_cin = 1'b1;
				state_d = csalu_pkg::ST_DONE;
			end
			csalu_pkg::ST_DONE: begin
				if (req.take) begin
					state_d = csalu_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = csalu_pkg::ST_IDLE;
			end
		endcase
	end

	// Datapath registers, loaded under control of the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			csalu_pkg::ST_IDLE: begin
				if (req.start) begin
					op_q    <= opcode;
					a_q     <= operand_a;
					b_q     <= operand_b;
					fault_q <= pre_fault;
					res_q   <= pre_res;
					neg_q   <= pre_neg;
					ebit_q  <= csalu_pkg::EXP_TOP;
					half_q  <= 1'b0;
					last_q  <= 1'b0;
				end
			end
			csalu_pkg::ST_MAGA: begin
				if (a_q[csalu_pkg::DATA_W-1]) begin
					a_q <= add_sum[csalu_pkg::DATA_W-1:0];
				end
			end
			csalu_pkg::ST_MAGB: begin
				b_q     <= abs_b;
				mx_q    <= a_q;
				my_q    <= abs_b;
				mstep_q <= 3'd0;
				acc_q   <= '0;
				rem_q   <= '0;
				quo_q   <= a_q;
				cnt_q   <= '0;
			end
			csalu_pkg::ST_ADD: begin
				res_q   <= add_sum[csalu_pkg::DATA_W-1:0];
				fault_q <= !add_ok;
			end
			csalu_pkg::ST_MUL: begin
				pp_q    <= mul_p;
				mstep_q <= mstep_q + 3'd1;
				if (mstep_q == 3'd1 || mstep_q == 3'd2 || mstep_q == 3'd3) begin
					acc_q <= add_sum;
				end
				if (mstep_q == 3'd4) begin
					if (mul_ovf) begin
						fault_q <= 1'b1;
					end else begin
						res_q <= acc_q[csalu_pkg::DATA_W-1:0];
					end
				end
			end
			csalu_pkg::ST_DIV: begin
				rem_q <= div_ge ? add_sum[csalu_pkg::DATA_W-1:0] : div_shift;
				quo_q <= {quo_q[csalu_pkg::DATA_W-2:0], div_ge};
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					res_q <= {quo_q[csalu_pkg::DATA_W-2:0], div_ge};
				end
			end
			csalu_pkg::ST_POW: begin
				// Left-to-right exponentiation: square, then multiply by the base on a set bit.
				if (!half_q) begin
					if (!last_q) begin
						mx_q    <= res_q;
						my_q    <= res_q;
						mstep_q <= 3'd0;
						acc_q   <= '0;
						half_q  <= 1'b1;
					end
				end else begin
					half_q <= 1'b0;
					if (ebit_q == 3'd0) begin
						last_q <= 1'b1;
					end else begin
						ebit_q <= ebit_q - 3'd1;
					end
					if (exp_bits[ebit_q]) begin
						mx_q    <= res_q;
						my_q    <= a_q;
						mstep_q <= 3'd0;
						acc_q   <= '0;
					end
				end
			end
			csalu_pkg::ST_SIGN: begin
				if (neg_q) begin
					res_q <= add_sum[csalu_pkg::DATA_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// A faulting power gives one, every other fault gives zero.
	assign value = fault_q ?
		((op_q == csalu_pkg::OP_POW) ? csalu_pkg::VAL_ONE : csalu_pkg::VAL_ZERO) : res_q;
	assign fault = fault_q;

	assign sts.idle = (state_q == csalu_pkg::ST_IDLE);
	assign sts.done = (state_q == csalu_pkg::ST_DONE);

endmodule
